// ===== hdl/nntt_pkg.sv =====
// Package: payload, twiddle entry and state types, function and register codes.
package nntt_pkg;

   typedef struct packed {
      logic [2:0]  func;
      logic [9:0]  index;
      logic [61:0] value;
      logic [63:0] value_quot;
      logic [61:0] inv_twiddle;
      logic [63:0] inv_twiddle_quot;
   } req_type;

   typedef struct packed {
      logic [61:0] coefficient;
      logic [9:0]  read_index;
   } rsp_type;

   typedef struct packed {
      logic [61:0] fw;
      logic [63:0] fwq;
      logic [61:0] iw;
      logic [63:0] iwq;
   } tw_type;

   localparam logic [2:0] FUNC_LOAD_TW = 3'd0;
   localparam logic [2:0] FUNC_WRITE   = 3'd1;
   localparam logic [2:0] FUNC_FORWARD = 3'd2;
   localparam logic [2:0] FUNC_INVERSE = 3'd3;
   localparam logic [2:0] FUNC_READ    = 3'd4;

   localparam int CSR_AW = 6;
   localparam logic [2:0] CSR_MODULUS  = 3'd0;
   localparam logic [2:0] CSR_LOG_DEG  = 3'd1;
   localparam logic [2:0] CSR_DINV     = 3'd2;
   localparam logic [2:0] CSR_DINV_Q   = 3'd3;
   localparam logic [2:0] CSR_DIT      = 3'd4;
   localparam logic [2:0] CSR_DIT_Q    = 3'd5;

   localparam logic [3:0] SHOUP_LAST_STEP = 4'd9;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BF_RDX,
      ST_BF_RDY,
      ST_BF_LOAD,
      ST_BF_START,
      ST_BF_MUL,
      ST_BF_WRX,
      ST_BF_WRY,
      ST_FIN_RD,
      ST_FIN_WR,
      ST_RD_OUT
   } state_type;

endpackage

// ===== hdl/nntt_shoup.sv =====
// Sequential Shoup modular product on one 32x32 multiplier, ten partial products.
module nntt_shoup (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] x,
   input  logic [63:0] w,
   input  logic [63:0] ws,
   input  logic [63:0] p,
   output logic        done,
   output logic [63:0] result
);

   logic [63:0]  x_ff, w_ff, ws_ff, p_ff;
   logic         run_ff;
   logic [3:0]   iss_ff;
   logic         pval_ff;
   logic [3:0]   pstep_ff;
   logic [63:0]  prod_ff;
   logic [127:0] acc_ff;
   logic [63:0]  lo_ff;
   logic         done_ff;
   logic [31:0]  op_a, op_b;

   // steps 0-3 build x*ws, 4-6 low word of x*w, 7-9 subtract q*p
   always_comb begin
      unique case (iss_ff)
         4'd0: begin op_a = x_ff[31:0];      op_b = ws_ff[31:0];  end
         4'd1: begin op_a = x_ff[31:0];      op_b = ws_ff[63:32]; end
         4'd2: begin op_a = x_ff[63:32];     op_b = ws_ff[31:0];  end
         4'd3: begin op_a = x_ff[63:32];     op_b = ws_ff[63:32]; end
         4'd4: begin op_a = x_ff[31:0];      op_b = w_ff[31:0];   end
         4'd5: begin op_a = x_ff[31:0];      op_b = w_ff[63:32];  end
         4'd6: begin op_a = x_ff[63:32];     op_b = w_ff[31:0];   end
         4'd7: begin op_a = acc_ff[95:64];   op_b = p_ff[31:0];   end
         4'd8: begin op_a = acc_ff[95:64];   op_b = p_ff[63:32];  end
         4'd9: begin op_a = acc_ff[127:96];  op_b = p_ff[31:0];   end
         default: begin op_a = 32'd0;        op_b = 32'd0;        end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         pval_ff <= 1'b0;
         done_ff <= 1'b0;
         iss_ff  <= 4'd0;
      end else begin
         pval_ff <= run_ff;
         done_ff <= pval_ff && (pstep_ff == nntt_pkg::SHOUP_LAST_STEP);
         if (start) begin
            run_ff <= 1'b1;
            iss_ff <= 4'd0;
         end else if (run_ff) begin
            if (iss_ff == nntt_pkg::SHOUP_LAST_STEP) run_ff <= 1'b0;
            iss_ff <= iss_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= 64'(op_a) * 64'(op_b);
      pstep_ff <= iss_ff;
      if (start) begin
         x_ff   <= x;
         w_ff   <= w;
         ws_ff  <= ws;
         p_ff   <= p;
         acc_ff <= 128'd0;
         lo_ff  <= 64'd0;
      end else if (pval_ff) begin
         unique case (pstep_ff)
            4'd0: acc_ff <= acc_ff + {64'd0, prod_ff};
            4'd1, 4'd2: acc_ff <= acc_ff + {32'd0, prod_ff, 32'd0};
            4'd3: acc_ff <= acc_ff + {prod_ff, 64'd0};
            4'd4: lo_ff <= lo_ff + prod_ff;
            4'd5, 4'd6: lo_ff <= lo_ff + {prod_ff[31:0], 32'd0};
            4'd7: lo_ff <= lo_ff - prod_ff;
            4'd8, 4'd9: lo_ff <= lo_ff - {prod_ff[31:0], 32'd0};
            default: lo_ff <= lo_ff;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = lo_ff;

endmodule

// ===== hdl/negacyclic_ntt_engine_unit.sv =====
// Top level: negacyclic NTT engine with coefficient and twiddle memories.
//
// Usage. Present an item on req_data with start high; it transfers at a
// clock edge where busy is low. Function codes: load twiddles (fills one
// entry of the twiddle memory), write coefficient, forward transform,
// inverse transform, read coefficient. Loads and writes finish in the
// transfer cycle and keep busy low. A read raises busy for one cycle and
// shows its result on rsp_data with rsp_valid high for exactly one cycle,
// registered from the memory read in the ST_RD_OUT state. The receiver cannot stall; the result is
// taken in the cycle it is shown.
// Transform steps: each butterfly does two memory reads, one pass of the
// 10-step Shoup unit on its single 32x32 multiplier and two writes back;
// the folded last inverse stage runs a second product per butterfly. Then
// a reduction pass reads and writes back each coefficient.
// The configuration registers sit on an APB port at byte address 8*i;
// write them only while busy is low. Reset clears control state, sets the
// registers to modulus 3, log degree 10, rest 0; memories undefined until written.
module negacyclic_ntt_engine_unit #(
   parameter int MAX_DEGREE = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  nntt_pkg::req_type     req_data,
   output logic                  rsp_valid,
   output nntt_pkg::rsp_type     rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [nntt_pkg::CSR_AW-1:0] paddr,
   input  logic [63:0]           pwdata,
   output logic [63:0]           prdata,
   output logic                  pready
);

   localparam int AW  = $clog2(MAX_DEGREE);
   localparam int LNW = $clog2(AW + 1);

   // configuration registers
   logic [61:0] mod_ff, dinv_ff, dit_ff;
   logic [63:0] dinvq_ff, ditq_ff;
   logic [3:0]  logd_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff   <= 62'd3;
         logd_ff  <= 4'd10;
         dinv_ff  <= 62'd0;
         dinvq_ff <= 64'd0;
         dit_ff   <= 62'd0;
         ditq_ff  <= 64'd0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            nntt_pkg::CSR_MODULUS: mod_ff   <= pwdata[61:0];
            nntt_pkg::CSR_LOG_DEG: logd_ff  <= pwdata[3:0];
            nntt_pkg::CSR_DINV:    dinv_ff  <= pwdata[61:0];
            nntt_pkg::CSR_DINV_Q:  dinvq_ff <= pwdata;
            nntt_pkg::CSR_DIT:     dit_ff   <= pwdata[61:0];
            nntt_pkg::CSR_DIT_Q:   ditq_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         nntt_pkg::CSR_MODULUS: prdata = {2'd0, mod_ff};
         nntt_pkg::CSR_LOG_DEG: prdata = {60'd0, logd_ff};
         nntt_pkg::CSR_DINV:    prdata = {2'd0, dinv_ff};
         nntt_pkg::CSR_DINV_Q:  prdata = dinvq_ff;
         nntt_pkg::CSR_DIT:     prdata = {2'd0, dit_ff};
         nntt_pkg::CSR_DIT_Q:   prdata = ditq_ff;
         default:               prdata = 64'd0;
      endcase
   end

   // control and datapath registers
   nntt_pkg::state_type state_ff, state_in;
   logic            inv_ff, phase_ff;
   logic [LNW-1:0]  lt_ff;
   logic [AW-1:0]   k_ff, c_ff;
   logic [63:0]     x_ff, y_ff, xn_ff, yn_ff;
   nntt_pkg::tw_type tw_ff;
   logic            rsp_valid_ff;
   nntt_pkg::rsp_type rsp_ff;
   logic [AW-1:0]   rd_idx_ff;

   // memories
   logic [63:0]      coef_mem [MAX_DEGREE];
   nntt_pkg::tw_type tw_mem   [MAX_DEGREE];
   logic [63:0]      coef_q_ff;
   nntt_pkg::tw_type tw_q_ff;
   logic             coef_we, tw_we;
   logic [AW-1:0]    coef_wa, coef_ra, tw_ra;
   logic [63:0]      coef_wd;

   // Shoup unit
   logic        sh_start, sh_done, sh_second;
   logic [63:0] sh_x, sh_w, sh_ws, sh_res;

   // derived geometry
   logic [LNW-1:0] ln;
   logic [AW:0]    n, half;
   logic [AW-1:0]  tmask, jmask, bi, xa, ya, twa, idx;
   logic           accept, k_last, stage_last, inv_last;
   logic [63:0]    p, p2, xv, sx, tx, dx, fin_a, fin_b;

   assign accept = start && (state_ff == nntt_pkg::ST_IDLE);
   assign busy   = (state_ff != nntt_pkg::ST_IDLE);
   assign idx    = AW'(req_data.index);

   // clamp the log degree to between 4 and the largest the memories hold
   assign ln = (logd_ff < 4'd4) ? LNW'(4) :
               ((int'(logd_ff) > AW) ? LNW'(AW) : LNW'(logd_ff));
   assign n    = (AW+1)'(1) << ln;
   assign half = n >> 1;

   assign tmask = AW'(1) << lt_ff;
   assign jmask = tmask - AW'(1);
   assign bi    = k_ff >> lt_ff;
   assign xa    = (bi << (lt_ff + LNW'(1))) | (k_ff & jmask);
   assign ya    = xa | tmask;
   assign twa   = inv_ff ? (AW'((AW+1)'(1) + n - (n >> lt_ff)) + bi)
                         : ((AW'(1) << (ln - LNW'(1) - lt_ff)) + bi);

   assign k_last     = (k_ff == AW'(half - (AW+1)'(1)));
   assign inv_last   = inv_ff && (lt_ff == ln - LNW'(1));
   assign stage_last = inv_ff ? inv_last : (lt_ff == LNW'(0));

   assign p   = {2'd0, mod_ff};
   assign p2  = {1'b0, mod_ff, 1'b0};
   assign xv  = (x_ff >= p2) ? x_ff - p2 : x_ff;
   assign sx  = x_ff + y_ff;
   assign tx  = (sx >= p2) ? sx - p2 : sx;
   assign dx  = x_ff + p2 - y_ff;
   assign fin_a = (coef_q_ff >= p2) ? coef_q_ff - p2 : coef_q_ff;
   assign fin_b = inv_ff ? ((coef_q_ff >= p) ? coef_q_ff - p : coef_q_ff)
                         : ((fin_a >= p) ? fin_a - p : fin_a);

   always_ff @(posedge clock) begin
      if (coef_we) coef_mem[coef_wa] <= coef_wd;
      coef_q_ff <= coef_mem[coef_ra];
   end

   always_ff @(posedge clock) begin
      if (tw_we) tw_mem[idx] <= {req_data.value, req_data.value_quot,
                                 req_data.inv_twiddle, req_data.inv_twiddle_quot};
      tw_q_ff <= tw_mem[tw_ra];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nntt_pkg::ST_IDLE: begin
            if (start) begin
               priority if (req_data.func == nntt_pkg::FUNC_FORWARD ||
                            req_data.func == nntt_pkg::FUNC_INVERSE)
                  state_in = nntt_pkg::ST_BF_RDX;
               else if (req_data.func == nntt_pkg::FUNC_READ)
                  state_in = nntt_pkg::ST_RD_OUT;
               else
                  state_in = nntt_pkg::ST_IDLE;
            end
         end
         nntt_pkg::ST_BF_RDX:   state_in = nntt_pkg::ST_BF_RDY;
         nntt_pkg::ST_BF_RDY:   state_in = nntt_pkg::ST_BF_LOAD;
         nntt_pkg::ST_BF_LOAD:  state_in = nntt_pkg::ST_BF_START;
         nntt_pkg::ST_BF_START: state_in = nntt_pkg::ST_BF_MUL;
         nntt_pkg::ST_BF_MUL: begin
            if (sh_done && !(inv_last && !phase_ff)) state_in = nntt_pkg::ST_BF_WRX;
         end
         nntt_pkg::ST_BF_WRX:   state_in = nntt_pkg::ST_BF_WRY;
         nntt_pkg::ST_BF_WRY: begin
            state_in = (k_last && stage_last) ? nntt_pkg::ST_FIN_RD : nntt_pkg::ST_BF_RDX;
         end
         nntt_pkg::ST_FIN_RD:   state_in = nntt_pkg::ST_FIN_WR;
         nntt_pkg::ST_FIN_WR: begin
            state_in = (c_ff == AW'(n - (AW+1)'(1))) ? nntt_pkg::ST_IDLE
                                                     : nntt_pkg::ST_FIN_RD;
         end
         nntt_pkg::ST_RD_OUT:   state_in = nntt_pkg::ST_IDLE;
         default:               state_in = nntt_pkg::ST_IDLE;
      endcase
   end

   // memory ports and Shoup unit control
   always_comb begin
      coef_we   = 1'b0;
      coef_wa   = xa;
      coef_wd   = xn_ff;
      coef_ra   = xa;
      tw_we     = 1'b0;
      tw_ra     = twa;
      sh_start  = 1'b0;
      sh_second = 1'b0;
      unique case (state_ff)
         nntt_pkg::ST_IDLE: begin
            coef_ra = idx;
            coef_wa = idx;
            coef_wd = {2'd0, req_data.value};
            coef_we = accept && (req_data.func == nntt_pkg::FUNC_WRITE);
            tw_we   = accept && (req_data.func == nntt_pkg::FUNC_LOAD_TW);
         end
         nntt_pkg::ST_BF_RDY:   coef_ra = ya;
         nntt_pkg::ST_BF_START: sh_start = 1'b1;
         nntt_pkg::ST_BF_MUL: begin
            // the folded last inverse stage runs a second product for y
            sh_second = 1'b1;
            sh_start  = sh_done && inv_last && !phase_ff;
         end
         nntt_pkg::ST_BF_WRX:   coef_we = 1'b1;
         nntt_pkg::ST_BF_WRY: begin
            coef_we = 1'b1;
            coef_wa = ya;
            coef_wd = yn_ff;
         end
         nntt_pkg::ST_FIN_RD:   coef_ra = c_ff;
         nntt_pkg::ST_FIN_WR: begin
            coef_we = 1'b1;
            coef_wa = c_ff;
            coef_wd = fin_b;
         end
         default: ;
      endcase
   end

   // operand select for the Shoup unit
   always_comb begin
      priority if (!inv_ff) begin
         sh_x  = y_ff;
         sh_w  = {2'd0, tw_ff.fw};
         sh_ws = tw_ff.fwq;
      end else if (!inv_last) begin
         sh_x  = dx;
         sh_w  = {2'd0, tw_ff.iw};
         sh_ws = tw_ff.iwq;
      end else if (!sh_second) begin
         sh_x  = tx;
         sh_w  = {2'd0, dinv_ff};
         sh_ws = dinvq_ff;
      end else begin
         sh_x  = dx;
         sh_w  = {2'd0, dit_ff};
         sh_ws = ditq_ff;
      end
   end

   nntt_shoup u_shoup (
      .clock  (clock),
      .reset  (reset),
      .start  (sh_start),
      .x      (sh_x),
      .w      (sh_w),
      .ws     (sh_ws),
      .p      (p),
      .done   (sh_done),
      .result (sh_res)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nntt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         inv_ff       <= 1'b0;
         phase_ff     <= 1'b0;
         lt_ff        <= '0;
         k_ff         <= '0;
         c_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == nntt_pkg::ST_RD_OUT);
         if (accept) begin
            inv_ff <= (req_data.func == nntt_pkg::FUNC_INVERSE);
            lt_ff  <= (req_data.func == nntt_pkg::FUNC_INVERSE) ? LNW'(0) : ln - LNW'(1);
            k_ff   <= '0;
         end
         if (state_ff == nntt_pkg::ST_BF_START) phase_ff <= 1'b0;
         if (state_ff == nntt_pkg::ST_BF_MUL && sh_done) phase_ff <= 1'b1;
         if (state_ff == nntt_pkg::ST_BF_WRY) begin
            // advance butterfly, then stage
            if (k_last) begin
               k_ff <= '0;
               c_ff <= '0;
               if (!stage_last) lt_ff <= inv_ff ? lt_ff + LNW'(1) : lt_ff - LNW'(1);
            end else begin
               k_ff <= k_ff + AW'(1);
            end
         end
         if (state_ff == nntt_pkg::ST_FIN_WR) c_ff <= c_ff + AW'(1);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) rd_idx_ff <= idx;
      if (state_ff == nntt_pkg::ST_BF_RDY) begin
         x_ff  <= coef_q_ff;
         tw_ff <= tw_q_ff;
      end
      if (state_ff == nntt_pkg::ST_BF_LOAD) y_ff <= coef_q_ff;
      if (state_ff == nntt_pkg::ST_BF_MUL && sh_done) begin
         priority if (!inv_ff) begin
            xn_ff <= xv + sh_res;
            yn_ff <= xv + p2 - sh_res;
         end else if (!inv_last) begin
            xn_ff <= tx;
            yn_ff <= sh_res;
         end else if (!phase_ff) begin
            xn_ff <= sh_res;
         end else begin
            yn_ff <= sh_res;
         end
      end
      if (state_ff == nntt_pkg::ST_RD_OUT) begin
         rsp_ff.coefficient <= coef_q_ff[61:0];
         rsp_ff.read_index  <= 10'(rd_idx_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
